[hdl/pls_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pls_pkg - shared types and constants for the positional list store
// Command codes, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;
    localparam int POS_W  = 6;

    // Command codes; the unused fourth code behaves as a delete
    localparam logic [CMD_W-1:0] CMD_INSERT_FRONT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND       = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE       = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_WRITE,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

endpackage : pls_pkg
`default_nettype wire

[hdl/pls_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pls_ram - simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pls_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : pls_ram
`default_nettype wire

[hdl/positional_list_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_store - bounded ordered list with insert/append/delete
// Holds up to CAPACITY signed words in a RAM, front at address 0. After each
// command the whole list is streamed out front to back.
//
//  channel  | direction | signals                                   | beat
//  ---------+-----------+-------------------------------------------+-----------
//  command  | in        | cmd_valid/cmd_ready, command value position| one command
//  result   | out       | res_valid/res_ready, item_value is_last    | one element
//           |           | list_empty was_ignored                     |
//
// Each command first moves S elements to open or close a gap, then writes the
// new value for an insert or append, then emits the N elements of the list; an
// empty list emits one zeroed beat in their place.
// Element moves go through the single RAM port pair: each is read in ST_SHIFT_RD
// and written in ST_SHIFT_WR. Output stalls hold the sequencer in its wait state.
// Commands are taken only when the sequencer is idle. Reset clears the count
// and state; RAM contents are never cleared (only live entries are read).
// ----------------------------------------------------------------------------
module positional_list_store
    import pls_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cmd_valid,
    output logic                          cmd_ready,
    input  wire logic [CMD_W-1:0]         command,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire logic [POS_W-1:0]         position,
    output logic                          res_valid,
    input  wire logic                     res_ready,
    output logic signed [DATA_W-1:0]      item_value,
    output logic                          is_last,
    output logic                          list_empty,
    output logic                          was_ignored
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = POS_W + 1;
    localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                up_reg, up_next;
    logic                ign_reg, ign_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [DATA_W-1:0]   out_val_reg, out_val_next;
    logic                out_last_reg, out_last_next;
    logic                out_empty_reg, out_empty_next;

    logic                ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]   ram_wr_addr, ram_rd_addr;
    logic [DATA_W-1:0]   ram_wr_data, ram_rd_data;

    logic [CNT_W-1:0]    step_idx;
    logic [CMP_W-1:0]    cnt_w, idx_w, pos_w;

    // shared index stepper: down while opening a gap, up otherwise
    assign step_idx = (up_reg && (state_reg == ST_SHIFT_RD || state_reg == ST_SHIFT_WR))
                    ? idx_reg - CNT_W'(1) : idx_reg + CNT_W'(1);
    assign cnt_w    = CMP_W'(cnt_reg);
    assign idx_w    = CMP_W'(idx_reg);
    assign pos_w    = CMP_W'(position);

    pls_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            up_reg    <= 1'b0;
            ign_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            up_reg    <= up_next;
            ign_reg   <= ign_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg       <= val_next;
        out_val_reg   <= out_val_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        up_next        = up_reg;
        ign_next       = ign_reg;
        val_next       = val_reg;
        out_val_next   = out_val_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = idx_reg[ADDR_W-1:0];
        ram_wr_data    = ram_rd_data;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = step_idx[ADDR_W-1:0];
        cmd_ready      = 1'b0;
        res_valid      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    val_next = value;
                    ign_next = 1'b0;
                    if (command == CMD_INSERT_FRONT)
                    begin
                        up_next = 1'b1;
                        idx_next = cnt_reg;
                        if (cnt_w >= CAP_C)
                        begin
                            ign_next   = 1'b1;
                            state_next = ST_EMIT_RD;
                        end
                        else if (cnt_reg == '0)
                        begin
                            state_next = ST_WRITE;
                        end
                        else
                        begin
                            state_next = ST_SHIFT_RD;
                        end
                    end
                    else if (command == CMD_APPEND)
                    begin
                        idx_next = cnt_reg;
                        if (cnt_w >= CAP_C)
                        begin
                            ign_next   = 1'b1;
                            state_next = ST_EMIT_RD;
                        end
                        else
                        begin
                            state_next = ST_WRITE;
                        end
                    end
                    else
                    begin
                        // delete; the spare code lands here too
                        up_next  = 1'b0;
                        idx_next = CNT_W'(position);
                        if (pos_w >= cnt_w)
                        begin
                            ign_next   = 1'b1;
                            state_next = ST_EMIT_RD;
                        end
                        else if (pos_w + CMP_W'(1) < cnt_w)
                        begin
                            state_next = ST_SHIFT_RD;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg - CNT_W'(1);
                            state_next = ST_EMIT_RD;
                        end
                    end
                end
            end

            ST_SHIFT_RD:
            begin
                ram_rd_en  = 1'b1;
                state_next = ST_SHIFT_WR;
            end

            ST_SHIFT_WR:
            begin
                ram_wr_en = 1'b1;
                idx_next  = step_idx;
                if (up_reg)
                begin
                    state_next = (step_idx == '0) ? ST_WRITE : ST_SHIFT_RD;
                end
                else if (idx_w + CMP_W'(2) < cnt_w)
                begin
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = ST_EMIT_RD;
                end
            end

            ST_WRITE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_data = val_reg;
                cnt_next    = cnt_reg + CNT_W'(1);
                state_next  = ST_EMIT_RD;
            end

            ST_EMIT_RD:
            begin
                idx_next = '0;
                if (cnt_reg == '0)
                begin
                    out_val_next   = '0;
                    out_last_next  = 1'b1;
                    out_empty_next = 1'b1;
                    state_next     = ST_EMIT_WAIT;
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = '0;
                    state_next  = ST_EMIT_LD;
                end
            end

            ST_EMIT_LD:
            begin
                out_val_next   = ram_rd_data;
                out_last_next  = (idx_w + CMP_W'(1) == cnt_w);
                out_empty_next = 1'b0;
                state_next     = ST_EMIT_WAIT;
            end

            ST_EMIT_WAIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    if (out_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram_rd_en  = 1'b1;
                        idx_next   = step_idx;
                        state_next = ST_EMIT_LD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign item_value  = out_val_reg;
    assign is_last     = out_last_reg;
    assign list_empty  = out_empty_reg;
    assign was_ignored = ign_reg;

endmodule : positional_list_store
`default_nettype wire

[hdl/pls_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pls_checker - port-level checks for the positional list store
// Watches the command and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module pls_checker
    import pls_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cmd_valid,
    input  wire logic                     cmd_ready,
    input  wire logic [CMD_W-1:0]         command,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire logic [POS_W-1:0]         position,
    input  wire logic                     res_valid,
    input  wire logic                     res_ready,
    input  wire logic signed [DATA_W-1:0] item_value,
    input  wire logic                     is_last,
    input  wire logic                     list_empty,
    input  wire logic                     was_ignored
);

    // a stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(item_value) && $stable(is_last)
        && $stable(list_empty) && $stable(was_ignored))
        else $error("result beat changed while stalled");

    // an empty list is a single, zeroed beat
    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && list_empty |-> is_last && item_value == '0)
        else $error("empty result not a zero last beat");

    // no new command while results are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !cmd_ready)
        else $error("command port ready during result stream");

    // the command port is not ready straight after a command is taken
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command port ready straight after a command");

endmodule : pls_checker

bind positional_list_store pls_checker u_pls_checker (.*);
`default_nettype wire
